// ===== rtl/wfss_pkg.sv =====
// ----------------------------------------------------------------------------
// wfss_pkg
// Shared types, register codes and the nice-to-weight table of the
// weighted fair slice scheduler.
// ----------------------------------------------------------------------------
package wfss_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int MAX_SLICES_DEF = 64;
    localparam int Q_DEPTH        = 2;
    localparam int DIV_BITS       = 40;
    localparam int DIVISOR_W      = 24;

    localparam logic [1:0] CFG_TARGET_LAT = 2'd0;
    localparam logic [1:0] CFG_MIN_GRAN   = 2'd1;
    localparam logic [1:0] CFG_START_TIME = 2'd2;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    localparam logic KIND_SLICE = 1'b0;
    localparam logic KIND_IDLE  = 1'b1;

    localparam logic [16:0] NICE_W [0:39] = '{
        17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291, 17'd29154,
        17'd23254, 17'd18705, 17'd14949, 17'd11916, 17'd9548, 17'd7620,
        17'd6100, 17'd4904, 17'd3906, 17'd3121, 17'd2501, 17'd1991,
        17'd1586, 17'd1277, 17'd1024, 17'd820, 17'd655, 17'd526,
        17'd423, 17'd335, 17'd272, 17'd215, 17'd172, 17'd137,
        17'd110, 17'd87, 17'd70, 17'd56, 17'd45, 17'd36,
        17'd29, 17'd23, 17'd18, 17'd15
    };

    typedef struct packed {
        logic        op;
        logic [7:0]  task_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [5:0]  nice;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  granted_id;
        logic [23:0] slice;
        logic [23:0] run_total;
        logic        done_res;
        logic [23:0] finish_time;
        logic [23:0] waited;
        logic [23:0] turnaround;
        logic [15:0] period;
        logic        capped;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] vruntime;
        logic [23:0] runtime;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [7:0]  id;
        logic [5:0]  nice;
        logic [23:0] waited;
        logic [15:0] order;
    } t_slot;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg;

    typedef struct packed {
        logic empty;
    } t_fstat;

    typedef struct packed {
        logic idle;
    } t_bstat;

    // clamp nice to -20..19 and look up its weight
    function automatic logic [16:0] weight_for(input logic [5:0] nice);
        logic signed [5:0] sn;
        logic [5:0]        idx;
        sn = signed'(nice);
        if (sn < -6'sd20) begin
            idx = 6'd0;
        end else if (sn > 6'sd19) begin
            idx = 6'd39;
        end else begin
            idx = 6'(sn + 6'sd20);
        end
        return NICE_W[idx];
    endfunction

endpackage

// ===== rtl/weighted_fair_slice_scheduler.sv =====
// Admit: a table scan, then the item is written to a free entry if one is found; no result.
// Run: each slice is a table scan at one entry per cycle, then two waits on
// the shared bit-serial divider.
// Empty run gives its single idle result after one table scan.
// One item in service at a time; the next starts after the table write or last result.
// Reset is synchronous, active low: table empty, registers at 20/4/0.
// ----------------------------------------------------------------------------
// weighted_fair_slice_scheduler
// Virtual-runtime slice scheduler: input queue in front, scheduling engine
// with task table and result register behind it.
// ----------------------------------------------------------------------------
module weighted_fair_slice_scheduler #(
    parameter int ENTRIES    = wfss_pkg::ENTRIES_DEF,
    parameter int MAX_SLICES = wfss_pkg::MAX_SLICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [7:0]        i_task_id,
    input  logic [15:0]       i_arrival,
    input  logic [15:0]       i_burst,
    input  logic signed [5:0] i_nice,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_granted_id,
    output logic [23:0]       o_slice,
    output logic [23:0]       o_run_total,
    output logic              o_done_res,
    output logic [23:0]       o_finish_time,
    output logic [23:0]       o_waited,
    output logic [23:0]       o_turnaround,
    output logic [15:0]       o_period,
    output logic              o_capped,
    output logic              o_last
);
    wfss_pkg::t_item  in_item;
    wfss_pkg::t_item  q_item;
    wfss_pkg::t_cfg   cfg;
    wfss_pkg::t_res   res;
    wfss_pkg::t_fstat fstat;
    wfss_pkg::t_bstat bstat;
    logic             q_valid;
    logic             q_pop;

    assign in_item.op      = i_op;
    assign in_item.task_id = i_task_id;
    assign in_item.arrival = i_arrival;
    assign in_item.burst   = i_burst;
    assign in_item.nice    = $unsigned(i_nice);

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    wfss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop),
        .o_stat    (fstat)
    );

    wfss_back #(
        .ENTRIES    (ENTRIES),
        .MAX_SLICES (MAX_SLICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out       (res),
        .o_stat      (bstat)
    );

    assign o_kind        = res.kind;
    assign o_granted_id  = res.granted_id;
    assign o_slice       = res.slice;
    assign o_run_total   = res.run_total;
    assign o_done_res    = res.done_res;
    assign o_finish_time = res.finish_time;
    assign o_waited      = res.waited;
    assign o_turnaround  = res.turnaround;
    assign o_period      = res.period;
    assign o_capped      = res.capped;
    assign o_last        = res.last;

`ifndef SYNTHESIS
    a_queue_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !fstat.empty)
        else $error("accepted transaction missing from queue");
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> !bstat.idle)
        else $error("engine idle while run still open");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> o_last)
        else $error("idle result not marked last");
    a_cap_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_capped) |-> (o_last && !o_kind))
        else $error("capped result not a final slice");
`endif

endmodule

// ===== rtl/wfss_front.sv =====
// ----------------------------------------------------------------------------
// wfss_front
// Input side: accepts items and holds them in a short queue for the
// scheduling engine.
// ----------------------------------------------------------------------------
module wfss_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  wfss_pkg::t_item i_item,
    output logic           o_q_valid,
    output wfss_pkg::t_item o_q_item,
    input  logic           i_q_pop,
    output wfss_pkg::t_fstat o_stat
);
    localparam int PW = (wfss_pkg::Q_DEPTH > 1) ? $clog2(wfss_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(wfss_pkg::Q_DEPTH + 1);

    wfss_pkg::t_item r_q [wfss_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            push;
    logic            pop;

    assign o_ready   = (r_cnt != CW'(wfss_pkg::Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rp];
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(wfss_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(wfss_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/wfss_div.sv =====
// ----------------------------------------------------------------------------
// wfss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfss_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [wfss_pkg::DIV_BITS-1:0]    i_dividend,
    input  logic [wfss_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                             o_done,
    output logic [wfss_pkg::DIV_BITS-1:0]    o_quot
);
    localparam int NW = wfss_pkg::DIV_BITS;
    localparam int DW = wfss_pkg::DIVISOR_W;
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

endmodule

// ===== rtl/wfss_back.sv =====
// ----------------------------------------------------------------------------
// wfss_back
// Scheduling engine: task table, selection scan, slice arithmetic and the
// result register.
// ----------------------------------------------------------------------------
module wfss_back #(
    parameter int ENTRIES    = wfss_pkg::ENTRIES_DEF,
    parameter int MAX_SLICES = wfss_pkg::MAX_SLICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wfss_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  wfss_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output wfss_pkg::t_res   o_out,
    output wfss_pkg::t_bstat o_stat
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = $clog2(MAX_SLICES + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_RDBEST = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIVS   = 4'd5;
    localparam logic [3:0] S_CLIP   = 4'd6;
    localparam logic [3:0] S_UPD    = 4'd7;
    localparam logic [3:0] S_VGO    = 4'd8;
    localparam logic [3:0] S_DIVV   = 4'd9;
    localparam logic [3:0] S_WRITE  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0]             r_state;
    logic [7:0]             r_tl;
    logic [7:0]             r_mg;
    logic [23:0]            r_time;
    logic [ENTRIES-1:0]     r_valid;
    logic [CW-1:0]          r_live;
    logic [15:0]            r_order;
    logic                   r_out_v;
    logic                   r_first;
    logic [KW-1:0]          r_k;
    logic [CW-1:0]          r_cnt;
    logic                   r_any;
    logic                   r_free_found;

    wfss_pkg::t_slot        r_mem [ENTRIES];
    wfss_pkg::t_slot        r_rd;
    wfss_pkg::t_item        r_item;
    wfss_pkg::t_res         r_res;
    wfss_pkg::t_res         r_out;
    logic [IW-1:0]          r_best;
    logic [31:0]            r_best_vr;
    logic [15:0]            r_best_ord;
    logic [IW-1:0]          r_free;
    logic [23:0]            r_wsum;
    logic [23:0]            r_run_wsum;
    logic [15:0]            r_period;
    logic [23:0]            r_used;
    logic [16:0]            r_w;
    logic [23:0]            r_sl;
    logic [23:0]            r_wait;
    logic [23:0]            r_newrt;
    logic                   r_done;
    logic [23:0]            r_ta;

    // scan element
    logic [CW-1:0]          jm1;
    logic [IW-1:0]          j;
    logic                   proc;
    logic                   beats;
    logic [IW-1:0]          rd_addr;

    // memory write port
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    wfss_pkg::t_slot        wr_data;

    // arithmetic
    logic [15:0]            nmg;
    logic [23:0]            per_fx;
    logic [39:0]            mul_p;
    logic                   div_start;
    logic [39:0]            div_dividend;
    logic [23:0]            div_divisor;
    logic                   div_done;
    logic [39:0]            div_quot;
    logic [23:0]            need;
    logic [23:0]            rem;
    logic [23:0]            s1;
    logic [23:0]            room;
    logic [23:0]            arr_fx;
    logic [23:0]            newrt;
    logic [23:0]            time_new;
    logic                   done_now;
    logic [23:0]            idle_time;
    logic [CW-1:0]          live_after;
    logic                   end_run;
    logic                   capped;
    logic                   out_free;
    logic                   emit;

    assign jm1     = r_cnt - 1'b1;
    assign j       = jm1[IW-1:0];
    assign proc    = (r_state == S_SCAN) && (r_cnt != '0);
    assign beats   = !r_any || (r_rd.vruntime < r_best_vr) ||
                     ((r_rd.vruntime == r_best_vr) && (r_rd.order < r_best_ord));
    assign rd_addr = ((r_state == S_SCAN) && (r_cnt < CW'(ENTRIES))) ? r_cnt[IW-1:0] : r_best;

    assign nmg    = 16'(r_live) * 16'(r_mg);
    assign per_fx = {r_period, 8'd0};
    assign mul_p  = {16'd0, per_fx} * {23'd0, wfss_pkg::weight_for(r_rd.nice)};

    assign need   = {r_rd.burst, 8'd0};
    assign rem    = (need > r_rd.runtime) ? (need - r_rd.runtime) : 24'd0;
    assign s1     = (div_quot[23:0] > rem) ? rem : div_quot[23:0];
    assign room   = per_fx - r_used;
    assign arr_fx = {r_rd.arrival, 8'd0};

    assign newrt    = r_rd.runtime + r_sl;
    assign time_new = r_time + r_sl;
    assign done_now = (newrt >= need);

    assign idle_time  = r_time + {r_tl, 8'd0};
    assign live_after = r_done ? (r_live - 1'b1) : r_live;
    assign end_run    = (r_used >= per_fx) || (live_after == '0);
    assign capped     = !end_run && ((r_k + 1'b1) == KW'(MAX_SLICES));
    assign out_free   = !r_out_v || i_out_ready;
    assign emit       = (r_state == S_EMIT) && out_free;

    assign div_start    = (r_state == S_MUL) || (r_state == S_VGO);
    assign div_dividend = (r_state == S_MUL) ? mul_p : {6'd0, r_newrt, 10'd0};
    assign div_divisor  = (r_state == S_MUL) ? r_run_wsum : {7'd0, r_w};

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign o_stat.idle = (r_state == S_IDLE);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best;
        wr_data = r_rd;
        if ((r_state == S_DECIDE) && (r_item.op == wfss_pkg::OP_ADMIT) && r_free_found) begin
            wr_en            = 1'b1;
            wr_addr          = r_free;
            wr_data.vruntime = r_any ? r_best_vr : 32'd0;
            wr_data.runtime  = 24'd0;
            wr_data.burst    = r_item.burst;
            wr_data.arrival  = r_item.arrival;
            wr_data.id       = r_item.task_id;
            wr_data.nice     = r_item.nice;
            wr_data.waited   = 24'd0;
            wr_data.order    = r_order;
        end else if (r_state == S_WRITE) begin
            wr_en            = 1'b1;
            wr_addr          = r_best;
            wr_data.vruntime = div_quot[31:0];
            wr_data.runtime  = r_newrt;
            wr_data.waited   = r_wait;
            wr_data.order    = r_done ? r_rd.order : r_order;
        end
    end

    wfss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tl         <= 8'd20;
            r_mg         <= 8'd4;
            r_time       <= '0;
            r_valid      <= '0;
            r_live       <= '0;
            r_order      <= '0;
            r_out_v      <= 1'b0;
            r_first      <= 1'b0;
            r_k          <= '0;
            r_cnt        <= '0;
            r_any        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state      <= S_SCAN;
                        r_first      <= 1'b1;
                        r_cnt        <= '0;
                        r_any        <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (proc) begin
                        if (r_valid[j]) begin
                            r_any <= 1'b1;
                        end else begin
                            r_free_found <= 1'b1;
                        end
                    end
                    if (r_cnt == CW'(ENTRIES)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (r_item.op == wfss_pkg::OP_ADMIT) begin
                        if (r_free_found) begin
                            r_valid[r_free] <= 1'b1;
                            r_live          <= r_live + 1'b1;
                            r_order         <= r_order + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end else if (r_first && !r_any) begin
                        r_time  <= idle_time;
                        r_state <= S_EMIT;
                    end else begin
                        if (r_first) begin
                            r_k <= '0;
                        end
                        r_state <= S_RDBEST;
                    end
                end
                S_RDBEST: r_state <= S_MUL;
                S_MUL:    r_state <= S_DIVS;
                S_DIVS: begin
                    if (div_done) begin
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: r_state <= S_UPD;
                S_UPD: begin
                    r_time  <= time_new;
                    r_state <= S_VGO;
                end
                S_VGO: r_state <= S_DIVV;
                S_DIVV: begin
                    if (div_done) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_done) begin
                        r_valid[r_best] <= 1'b0;
                        r_live          <= r_live - 1'b1;
                    end else begin
                        r_order <= r_order + 1'b1;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_res.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state      <= S_SCAN;
                            r_first      <= 1'b0;
                            r_cnt        <= '0;
                            r_any        <= 1'b0;
                            r_free_found <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    wfss_pkg::CFG_TARGET_LAT: r_tl   <= i_cfg.data[7:0];
                    wfss_pkg::CFG_MIN_GRAN:   r_mg   <= i_cfg.data[7:0];
                    wfss_pkg::CFG_START_TIME: r_time <= {i_cfg.data, 8'd0};
                    default: ;
                endcase
            end
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if ((r_state == S_SCAN) || (r_state == S_RDBEST)) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_q_item;
                r_wsum <= '0;
            end
            S_SCAN: begin
                if (proc) begin
                    if (r_valid[j]) begin
                        r_wsum <= r_wsum + 24'(wfss_pkg::weight_for(r_rd.nice));
                        if (beats) begin
                            r_best     <= j;
                            r_best_vr  <= r_rd.vruntime;
                            r_best_ord <= r_rd.order;
                        end
                    end else if (!r_free_found) begin
                        r_free <= j;
                    end
                end
            end
            S_DECIDE: begin
                if (r_first && !r_any) begin
                    r_res <= '{kind: wfss_pkg::KIND_IDLE, finish_time: idle_time,
                               period: {8'd0, r_tl}, last: 1'b1, default: '0};
                end else if (r_first) begin
                    r_period   <= ((r_mg == 8'd0) || (nmg <= {8'd0, r_tl})) ?
                                  {8'd0, r_tl} : nmg;
                    r_run_wsum <= r_wsum;
                    r_used     <= '0;
                end
            end
            S_MUL: begin
                r_w <= wfss_pkg::weight_for(r_rd.nice);
            end
            S_CLIP: begin
                r_sl <= (s1 > room) ? room : s1;
                if (r_rd.runtime == 24'd0) begin
                    r_wait <= (r_time >= arr_fx) ? (r_time - arr_fx) : 24'd0;
                end else begin
                    r_wait <= r_rd.waited;
                end
            end
            S_UPD: begin
                r_newrt <= newrt;
                r_used  <= r_used + r_sl;
                r_done  <= done_now;
                r_ta    <= (done_now && (time_new >= arr_fx)) ? (time_new - arr_fx) : 24'd0;
            end
            S_WRITE: begin
                r_res.kind        <= wfss_pkg::KIND_SLICE;
                r_res.granted_id  <= r_rd.id;
                r_res.slice       <= r_sl;
                r_res.run_total   <= r_newrt;
                r_res.done_res    <= r_done;
                r_res.finish_time <= r_time;
                r_res.waited      <= r_wait;
                r_res.turnaround  <= r_ta;
                r_res.period      <= r_period;
                r_res.capped      <= capped;
                r_res.last        <= end_run || capped;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out  <= r_res;
                    r_wsum <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule
